// ===== hw/rtl/pcpa_pkg.sv =====
// shared types, constants and codes of the per-cpu page allocator
package pcpa_pkg;

  localparam int unsigned NumCpusDefault   = 8;
  localparam int unsigned NumPagesDefault  = 32768;
  localparam int unsigned PageBytesDefault = 4096;

  localparam logic [31:0] RegionStartReset = 32'h8000_0000;
  localparam logic [31:0] RegionStopReset  = 32'h8800_0000;

  localparam int unsigned CfgIndexWidth = 8;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgRegionStart = 8'd0,
    CfgRegionStop  = 8'd1
  } cfg_idx_e;

  typedef enum logic {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StOk  = 2'd0,
    StOom = 2'd1,
    StBad = 2'd2
  } status_e;

  typedef struct packed {
    logic        op;
    logic [2:0]  cpu;
    logic [31:0] addr;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] page_addr;
    logic [2:0]  from_cpu;
  } out_t;

endpackage

// ===== hw/rtl/pcpa_link_ram.sv =====
// next-link memory: one write port, one registered read port
module pcpa_link_ram #(
  parameter int unsigned Depth = pcpa_pkg::NumPagesDefault,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pcpa_addr_check.sv =====
// free address check and page number of a freed address
module pcpa_addr_check #(
  parameter int unsigned NumPages  = pcpa_pkg::NumPagesDefault,
  parameter int unsigned PageBytes = pcpa_pkg::PageBytesDefault
) (
  input  logic [31:0]                 addr_i,
  input  logic [31:0]                 start_i,
  input  logic [31:0]                 stop_i,
  input  logic [32:0]                 base_i,
  output logic                        ok_o,
  output logic [$clog2(NumPages)-1:0] idx_o
);

  localparam int unsigned PB = $clog2(PageBytes);
  localparam int unsigned PW = $clog2(NumPages);

  logic [32:0]   diff;
  logic [32-PB:0] pages;
  logic          aligned, above_start, below_stop, above_base, in_range;

  assign diff        = {1'b0, addr_i} - base_i;
  assign pages       = diff[32:PB];
  assign aligned     = (addr_i[PB-1:0] == '0);
  assign above_start = (addr_i >= start_i);
  assign below_stop  = (addr_i < stop_i);
  assign above_base  = ({1'b0, addr_i} >= base_i);
  assign in_range    = (33'(pages) < 33'(NumPages));

  assign ok_o  = aligned && above_start && below_stop && above_base && in_range;
  assign idx_o = pages[PW-1:0];

endmodule

// ===== hw/rtl/per_cpu_page_allocator_core.sv =====
// per-cpu lifo page allocator with stealing: head registers plus next-link memory
// flow: the item is held in SExec, which emits a free or out-of-memory result
//   or reads the next-link memory for a pop, whose result SPop then emits
// a new item is accepted only in SIdle, after the last result is emitted
// reset: all lists empty, region registers to defaults, link memory left uncleared
// a stalled result holds the block before it changes any list state
module per_cpu_page_allocator_core #(
  parameter int unsigned NumCpus   = pcpa_pkg::NumCpusDefault,
  parameter int unsigned NumPages  = pcpa_pkg::NumPagesDefault,
  parameter int unsigned PageBytes = pcpa_pkg::PageBytesDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pcpa_pkg::in_t                       in_item_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pcpa_pkg::out_t                      out_item_o,
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pcpa_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [31:0]                         cfg_data_i
);

  import pcpa_pkg::*;

  localparam int unsigned PB = $clog2(PageBytes);
  localparam int unsigned PW = $clog2(NumPages);
  localparam int unsigned CW = (NumCpus > 1) ? $clog2(NumCpus) : 1;

  typedef enum logic [2:0] {
    SIdle = 3'b001,
    SExec = 3'b010,
    SPop  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // region registers
  logic [31:0] start_q, stop_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= RegionStartReset;
      stop_q  <= RegionStopReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgRegionStart: start_q <= cfg_data_i;
        CfgRegionStop:  stop_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // base: region start rounded up to a page boundary, may reach 2^32
  logic [32-PB:0] base_pg;
  logic [32:0]    base;

  assign base_pg = {1'b0, start_q[31:PB]} + (33-PB)'(|start_q[PB-1:0]);
  assign base    = {base_pg, {PB{1'b0}}};

  // held item
  in_t item_q;

  assign in_stall_o = (state_q != SIdle);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_item_i;
    end
  end

  // requesting cpu reduced modulo the cpu count through a constant table
  logic [CW-1:0] cpu_tab [8];
  logic [CW-1:0] cpu_m;

  for (genvar g = 0; g < 8; g++) begin : g_cpu_tab
    assign cpu_tab[g] = CW'(g % NumCpus);
  end

  assign cpu_m = cpu_tab[item_q.cpu];

  // list heads: one register and valid bit per cpu
  logic [PW-1:0] heads_q [NumCpus];
  logic          head_vld_q [NumCpus];

  // steal search: first non-empty list from cpu onward, wrapping
  logic          found;
  logic [CW-1:0] found_c;

  always_comb begin
    logic [CW:0] sum;
    found   = 1'b0;
    found_c = '0;
    sum     = '0;
    for (int i = NumCpus - 1; i >= 0; i--) begin
      sum = {1'b0, cpu_m} + (CW+1)'(i);
      if (sum >= (CW+1)'(NumCpus)) begin
        sum = sum - (CW+1)'(NumCpus);
      end
      if (head_vld_q[sum[CW-1:0]]) begin
        found   = 1'b1;
        found_c = sum[CW-1:0];
      end
    end
  end

  // single read of the head array at the selected list
  logic [CW-1:0] hd_sel;
  logic [PW-1:0] hd_idx;
  logic          hd_vld;

  assign hd_sel = (item_q.op == OpFree) ? cpu_m : found_c;
  assign hd_idx = heads_q[hd_sel];
  assign hd_vld = head_vld_q[hd_sel];

  // free address check
  logic          free_ok;
  logic [PW-1:0] free_idx;

  pcpa_addr_check #(
    .NumPages  (NumPages),
    .PageBytes (PageBytes)
  ) u_check (
    .addr_i  (item_q.addr),
    .start_i (start_q),
    .stop_i  (stop_q),
    .base_i  (base),
    .ok_o    (free_ok),
    .idx_o   (free_idx)
  );

  // next-link memory, each word holds the link and whether it points anywhere
  logic          mem_we, mem_re;
  logic [PW:0]   mem_rdata;

  pcpa_link_ram #(
    .Depth (NumPages),
    .Width (PW + 1)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (free_idx),
    .wdata_i ({hd_vld, hd_idx}),
    .re_i    (mem_re),
    .raddr_i (hd_idx),
    .rdata_o (mem_rdata)
  );

  // output register
  logic  out_valid_q;
  out_t  out_item_q;
  logic  out_free;
  logic  emit;
  out_t  emit_item;

  assign out_free = !out_valid_q || !out_stall_i;

  // popped page bookkeeping between the read and the write-back
  logic [CW-1:0] pop_c_q;
  logic [31:0]   pop_addr_q;

  logic          push_en, pop_en;

  always_comb begin
    state_d   = state_q;
    emit      = 1'b0;
    emit_item = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    push_en   = 1'b0;
    pop_en    = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          state_d = SExec;
        end
      end
      SExec: begin
        if (item_q.op == OpFree) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = SIdle;
            if (free_ok) begin
              mem_we  = 1'b1;
              push_en = 1'b1;
              emit_item.status = StOk;
            end else begin
              emit_item.status = StBad;
            end
          end
        end else if (found) begin
          // fetch the link of the head page, write-back follows
          mem_re  = 1'b1;
          state_d = SPop;
        end else if (out_free) begin
          emit             = 1'b1;
          emit_item.status = StOom;
          state_d          = SIdle;
        end
      end
      SPop: begin
        if (out_free) begin
          emit                = 1'b1;
          pop_en              = 1'b1;
          emit_item.status    = StOk;
          emit_item.page_addr = pop_addr_q;
          emit_item.from_cpu  = 3'(pop_c_q);
          state_d             = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      pop_c_q    <= found_c;
      pop_addr_q <= base[31:0] + (32'(hd_idx) << PB);
    end
  end

  // head registers: push writes the freed page, pop writes the fetched link
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCpus; i++) begin
        head_vld_q[i] <= 1'b0;
      end
    end else if (push_en) begin
      head_vld_q[cpu_m] <= 1'b1;
    end else if (pop_en) begin
      head_vld_q[pop_c_q] <= mem_rdata[PW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      heads_q[cpu_m] <= free_idx;
    end else if (pop_en) begin
      heads_q[pop_c_q] <= mem_rdata[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_item_q <= emit_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
